>>> hw/rtl/sbgo_pkg.sv
// Shared constants for the scrolling bar graph overlay.
// Register indexes, reset values and divider widths; no dependencies.
`default_nettype none

package sbgo_pkg;

  localparam int DEF_MAX_COLUMNS = 64;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 8;
  localparam int LOAD_W  = 7;
  localparam int GLEN_W  = 7;
  localparam int COLOR_W = 24;
  localparam int ORG_W   = 12;
  localparam int SCR_W   = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_HEIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAPH_LENGTH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BOTTOM = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOP    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 4'd7;

  localparam logic [7:0]          RST_TICKS        = 8'd25;
  localparam logic [7:0]          RST_BAR_HEIGHT   = 8'd30;
  localparam logic [GLEN_W-1:0]   RST_GRAPH_LENGTH = 7'd30;
  localparam logic [COLOR_W-1:0]  RST_COLOR_BOTTOM = 24'h000000;
  localparam logic [COLOR_W-1:0]  RST_COLOR_TOP    = 24'hFFFFFF;

  localparam logic [LOAD_W-1:0] PCT_FULL = 7'd100;

  // x/100 == (x*5243)>>19 for x below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam int DIV_DW = 15;
  localparam int DIV_VW = 8;
  localparam int DIV_QW = 7;

endpackage

`default_nettype wire

>>> hw/rtl/sbgo_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sbgo_pkg for its widths.
`default_nettype none

module sbgo_div import sbgo_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_DW-1:0] dividend,
  input  wire logic [DIV_VW-1:0] divisor,
  output logic                   done,
  output logic [DIV_QW-1:0]      quotient,
  output logic [DIV_VW-1:0]      remainder
);

  localparam int CNT_W = $clog2(DIV_QW);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_QW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_DW-1:0] trial;

  assign trial = DIV_DW'(dvs_r) << cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_QW - 1);
        rem_r  <= dividend;
        quo_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r        <= rem_r - trial;
          quo_r[cnt_r] <= 1'b1;
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[DIV_VW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/scrolling_bar_graph_overlay.sv
// Top level of the scrolling bar graph overlay.
// Depends on sbgo_pkg and sbgo_div.
//
// Tick items (mode 0) count toward ticks_per_sample while enabled; on a match the
// bar height bar_height*load/100 is written into the ring slot of the oldest column
// and the ring pointer advances, through S_TICK. Pixel items (mode 1) read the
// history memory once and produce one result item through S_LOOK, S_DIV, S_MUL,
// S_QUO and S_FIN, the divider in S_DIV forming 100*row/bar_height for the gradient
// level; the next item is accepted after the result is loaded in S_FIN. After
// graph_length is written at or below the ring pointer, the next item waits in
// S_NORM while the same divider takes the pointer modulo the length. The history
// resets to zero through per-column valid bits, so no clearing pass follows reset.
// The next item is accepted while a result waits.
`default_nettype none

module scrolling_bar_graph_overlay import sbgo_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [LOAD_W-1:0]     in_load_percent,
  input  wire logic [COL_W-1:0]      in_column,
  input  wire logic [ROW_W-1:0]      in_row,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_drawn,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic [SCR_W-1:0]           out_screen_x,
  output logic [SCR_W-1:0]           out_screen_y,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int GLEN_MAX = 2 ** GLEN_W;
  localparam int DEPTH = (MAX_COLUMNS < GLEN_MAX) ? MAX_COLUMNS : GLEN_MAX;
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int SW    = ((PW > COL_W) ? PW : COL_W) + 1;
  localparam int CW    = (LW > COL_W) ? LW : COL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_TICK, S_LOOK, S_DIV, S_MUL, S_QUO, S_FIN
  } state_t;

  state_t state_r;

  logic               en_r;
  logic [7:0]         tps_r;
  logic [7:0]         bh_r;
  logic [GLEN_W-1:0]  gl_r;
  logic [COLOR_W-1:0] cb_r;
  logic [COLOR_W-1:0] ct_r;
  logic [ORG_W-1:0]   ox_r;
  logic [ORG_W-1:0]   oy_r;

  logic [7:0]    tick_cnt_r;
  logic [7:0]    tick_cnt_nxt;
  logic [PW-1:0] ptr_r;
  logic [PW-1:0] ptr_nxt;
  logic [PW-1:0] mod_r;
  logic          mod_ok_r;
  logic [LW-1:0] norm_len_r;

  logic [7:0]    mem [DEPTH];
  logic          vld_r [DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [14:0]      hprod_r;
  logic             hit_r;
  logic signed [16:0] prod_r [3];
  logic [7:0]       color_r [3];

  logic          out_valid_r;
  logic          drawn_r;
  logic [7:0]    red_r;
  logic [7:0]    green_r;
  logic [7:0]    blue_r;
  logic [SCR_W-1:0] sx_r;
  logic [SCR_W-1:0] sy_r;

  logic [LW-1:0]     len;
  logic              ptr_bad;
  logic              norm_need;
  logic [PW-1:0]     p_eff;
  logic              glen_wr;
  logic [LW-1:0]     ptr_inc;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     idx;
  logic              col_fits;
  logic [PW-1:0]     rd_addr;
  logic              in_acc;
  logic [LOAD_W-1:0] load_sat;
  logic [27:0]       h_full;
  logic [7:0]        h_new;
  logic [7:0]        h_cur;
  logic              pre_ok;
  logic [14:0]       row100;
  logic              out_free;

  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_QW-1:0] div_quo;
  logic [DIV_VW-1:0] div_rem;

  logic signed [7:0]  level;
  logic signed [8:0]  diff [3];
  logic [15:0]        mag [3];
  logic [28:0]        qfull [3];
  logic [9:0]         qmag [3];
  logic [9:0]         qsig [3];

  always_comb begin
    if (gl_r == '0) begin
      len = LW'(1);
    end else if (int'(gl_r) > MAX_COLUMNS) begin
      len = LW'(DEPTH);
    end else begin
      len = LW'(gl_r);
    end
  end

  assign ptr_bad   = LW'(ptr_r) >= len;
  assign norm_need = ptr_bad && !mod_ok_r;
  assign p_eff     = ptr_bad ? mod_r : ptr_r;
  assign glen_wr   = cfg_valid && (cfg_index == REG_GRAPH_LENGTH);
  assign ptr_inc   = LW'(p_eff) + LW'(1);
  assign ptr_nxt   = (ptr_inc == len) ? '0 : ptr_inc[PW-1:0];

  assign sum      = SW'(p_eff) + SW'(in_column);
  assign idx      = (sum >= SW'(len)) ? (sum - SW'(len)) : sum;
  assign col_fits = CW'(in_column) < CW'(len);
  assign rd_addr  = col_fits ? idx[PW-1:0] : '0;

  assign in_stall = !(state_r == S_IDLE && !norm_need);
  assign in_acc   = in_valid && !in_stall;

  assign load_sat     = (in_load_percent > PCT_FULL) ? PCT_FULL : in_load_percent;
  assign tick_cnt_nxt = tick_cnt_r + 8'd1;

  assign h_full = 28'(hprod_r) * 28'(RECIP_100);
  assign h_new  = h_full[RECIP_SHIFT+7:RECIP_SHIFT];

  assign h_cur  = rd_vld_r ? rd_data_r : 8'd0;
  assign pre_ok = en_r && (CW'(col_r) < CW'(len)) && (row_r < bh_r);
  assign row100 = (15'(row_r) << 6) + (15'(row_r) << 5) + (15'(row_r) << 2);

  assign div_start    = (state_r == S_IDLE && norm_need) || state_r == S_LOOK;
  assign div_dividend = (state_r == S_LOOK) ? row100 : DIV_DW'(ptr_r);
  assign div_divisor  = (state_r == S_LOOK) ? bh_r : DIV_VW'(len);

  sbgo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign level = 8'sd100 - $signed({1'b0, div_quo});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]  = $signed({1'b0, ct_r[8*c +: 8]}) - $signed({1'b0, cb_r[8*c +: 8]});
      mag[c]   = prod_r[c][16] ? 16'(-prod_r[c]) : 16'(prod_r[c]);
      qfull[c] = 29'(mag[c]) * 29'(RECIP_100);
      qmag[c]  = qfull[c][RECIP_SHIFT+9:RECIP_SHIFT];
      qsig[c]  = prod_r[c][16] ? (10'd0 - qmag[c]) : qmag[c];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (in_acc && in_mode) begin
      rd_data_r <= mem[rd_addr];
    end
    if (state_r == S_TICK) begin
      mem[p_eff] <= h_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      tps_r       <= RST_TICKS;
      bh_r        <= RST_BAR_HEIGHT;
      gl_r        <= RST_GRAPH_LENGTH;
      cb_r        <= RST_COLOR_BOTTOM;
      ct_r        <= RST_COLOR_TOP;
      ox_r        <= '0;
      oy_r        <= '0;
      tick_cnt_r  <= '0;
      ptr_r       <= '0;
      mod_r       <= '0;
      mod_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ENABLE:       en_r <= cfg_data[0];
          REG_TICKS:        tps_r <= cfg_data[7:0];
          REG_BAR_HEIGHT:   bh_r <= cfg_data[7:0];
          REG_GRAPH_LENGTH: gl_r <= cfg_data[GLEN_W-1:0];
          REG_COLOR_BOTTOM: cb_r <= cfg_data[COLOR_W-1:0];
          REG_COLOR_TOP:    ct_r <= cfg_data[COLOR_W-1:0];
          REG_ORIGIN_X:     ox_r <= cfg_data[ORG_W-1:0];
          REG_ORIGIN_Y:     oy_r <= cfg_data[ORG_W-1:0];
          default: ;
        endcase
      end

      if (glen_wr) begin
        mod_ok_r <= 1'b0;
      end else if (state_r == S_NORM && div_done && norm_len_r == len) begin
        mod_ok_r <= 1'b1;
      end

      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (norm_need) begin
            norm_len_r <= len;
            state_r    <= S_NORM;
          end else if (in_acc) begin
            if (in_mode) begin
              col_r    <= in_column;
              row_r    <= in_row;
              rd_vld_r <= vld_r[rd_addr];
              state_r  <= S_LOOK;
            end else if (en_r) begin
              if (tick_cnt_nxt == tps_r) begin
                tick_cnt_r <= '0;
                hprod_r    <= 15'(bh_r) * 15'(load_sat);
                state_r    <= S_TICK;
              end else begin
                tick_cnt_r <= tick_cnt_nxt;
              end
            end
          end
        end
        S_NORM: begin
          if (div_done) begin
            mod_r   <= div_rem[PW-1:0];
            state_r <= S_IDLE;
          end
        end
        S_TICK: begin
          vld_r[p_eff] <= 1'b1;
          ptr_r        <= ptr_nxt;
          state_r      <= S_IDLE;
        end
        S_LOOK: begin
          hit_r   <= pre_ok && ((9'(row_r) + 9'(h_cur)) >= 9'(bh_r));
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            for (int c = 0; c < 3; c++) begin
              prod_r[c] <= 17'(level) * 17'(diff[c]);
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          for (int c = 0; c < 3; c++) begin
            color_r[c] <= 8'(10'(cb_r[8*c +: 8]) + qsig[c]);
          end
          state_r <= S_QUO;
        end
        S_QUO: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            drawn_r     <= hit_r;
            red_r       <= hit_r ? color_r[2] : 8'd0;
            green_r     <= hit_r ? color_r[1] : 8'd0;
            blue_r      <= hit_r ? color_r[0] : 8'd0;
            sx_r        <= SCR_W'(ox_r) + SCR_W'(col_r);
            sy_r        <= SCR_W'(oy_r) + SCR_W'(row_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_drawn    = drawn_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;

endmodule

`default_nettype wire

>>> dv/tb_scrolling_bar_graph_overlay.sv
// Testbench for scrolling_bar_graph_overlay: tick and pixel items with random stalls.
// Holds its own copy of the column history and checks every pixel result by field.
// Depends on sbgo_pkg and the RTL of the block.
`default_nettype none

module tb_scrolling_bar_graph_overlay;
  import sbgo_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 80;

  typedef struct packed {
    logic              mode;
    logic [LOAD_W-1:0] load;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } bar_req_t;

  typedef struct packed {
    logic             drawn;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [LOAD_W-1:0]     in_load_percent = '0;
  logic [COL_W-1:0]      in_column = '0;
  logic [ROW_W-1:0]      in_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_drawn;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [SCR_W-1:0]      out_screen_x;
  logic [SCR_W-1:0]      out_screen_y;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow
  logic              en_r   = 1'b0;
  logic [7:0]        rate_r = RST_TICKS;
  logic [7:0]        dh_r   = RST_BAR_HEIGHT;
  logic [GLEN_W-1:0] glen_r = RST_GRAPH_LENGTH;
  logic [COLOR_W-1:0] bot_r = RST_COLOR_BOTTOM;
  logic [COLOR_W-1:0] top_r = RST_COLOR_TOP;
  logic [ORG_W-1:0]  ox_r   = '0;
  logic [ORG_W-1:0]  oy_r   = '0;

  // history shadow
  logic [7:0]  tick_cnt = '0;
  logic [7:0]  col_h [DEF_MAX_COLUMNS] = '{default: '0};
  int unsigned ring_head = 0;

  bar_req_t pend_q [$];
  pixel_t   pixel_q [$];
  bar_req_t nxt;
  pixel_t   want;
  logic     in_took = 1'b0;
  int       send_idle_pct = 9;
  int       recv_idle_pct = 50;
  int       items_in = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       errors = 0;
  int       cycles = 0;

  scrolling_bar_graph_overlay uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_load_percent (in_load_percent),
    .in_column       (in_column),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn       (out_drawn),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned used_len();
    int unsigned n;
    n = glen_r;
    if (n == 0) n = 1;
    if (n > DEF_MAX_COLUMNS) n = DEF_MAX_COLUMNS;
    return n;
  endfunction

  function automatic logic [7:0] shade(input logic [7:0] b, input logic [7:0] t,
                                       input int lvl);
    int d;
    d = lvl * (int'(t) - int'(b)) / 100 + int'(b);
    return d[7:0];
  endfunction

  task automatic store_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ENABLE:       en_r   = d[0];
      REG_TICKS:        rate_r = d[7:0];
      REG_BAR_HEIGHT:   dh_r   = d[7:0];
      REG_GRAPH_LENGTH: glen_r = d[GLEN_W-1:0];
      REG_COLOR_BOTTOM: bot_r  = d[COLOR_W-1:0];
      REG_COLOR_TOP:    top_r  = d[COLOR_W-1:0];
      REG_ORIGIN_X:     ox_r   = d[ORG_W-1:0];
      REG_ORIGIN_Y:     oy_r   = d[ORG_W-1:0];
      default: ;
    endcase
  endtask

  // scroll the history on a tick, or work out the pixel of a query
  task automatic graph_step(input bar_req_t rq);
    int unsigned len, p, ld, col, row, h;
    int lvl;
    pixel_t px;
    len = used_len();
    p = ring_head % len;
    if (rq.mode == MODE_TICK) begin
      if (en_r) begin
        ld = (rq.load > 100) ? 100 : rq.load;
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt == rate_r) begin
          tick_cnt = '0;
          col_h[p] = 8'((int'(dh_r) * ld) / 100);
          ring_head = (p + 1) % len;
        end
      end
    end else begin
      px = '0;
      col = rq.column;
      row = rq.row;
      if (en_r && col < len && row < dh_r) begin
        h = col_h[(p + col) % len];
        px.drawn = (row + h >= dh_r);
      end
      if (px.drawn) begin
        lvl = 100 - int'((100 * row) / dh_r);
        px.red   = shade(bot_r[23:16], top_r[23:16], lvl);
        px.green = shade(bot_r[15:8], top_r[15:8], lvl);
        px.blue  = shade(bot_r[7:0], top_r[7:0], lvl);
      end
      px.screen_x = SCR_W'(ox_r + col);
      px.screen_y = SCR_W'(oy_r + row);
      pixel_q.push_back(px);
    end
  endtask

  task automatic check_field(input string name, input logic [SCR_W-1:0] exp_v,
                             input logic [SCR_W-1:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got);
      errors++;
    end
  endtask

  // monitor: config shadow, input prediction, result check
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("result item with none expected");
          errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("drawn", SCR_W'(want.drawn), SCR_W'(out_drawn));
          check_field("red", SCR_W'(want.red), SCR_W'(out_red));
          check_field("green", SCR_W'(want.green), SCR_W'(out_green));
          check_field("blue", SCR_W'(want.blue), SCR_W'(out_blue));
          check_field("screen_x", want.screen_x, out_screen_x);
          check_field("screen_y", want.screen_y, out_screen_y);
        end
      end
      if (in_valid && !in_stall) begin
        graph_step('{in_mode, in_load_percent, in_column, in_row});
        items_in++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (rst_n && pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pend_q.pop_front();
        in_valid        <= 1'b1;
        in_mode         <= nxt.mode;
        in_load_percent <= nxt.load;
        in_column       <= nxt.column;
        in_row          <= nxt.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold to back up the block
  always @(negedge clk) begin
    if (hold_left == 0 && !hold_done && items_in >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_scrolling_bar_graph_overlay: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val,
                           input int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1) == 0) junk = '0;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (w >= CFG_DATA_W) ? CFG_DATA_W'(val) : ((junk << w) | CFG_DATA_W'(val));
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_tick(input int unsigned load);
    pend_q.push_back('{MODE_TICK, LOAD_W'(load), '0, '0});
  endtask

  task automatic queue_pixel(input int unsigned col, input int unsigned row);
    pend_q.push_back('{MODE_PIXEL, '0, COL_W'(col), ROW_W'(row)});
  endtask

  task automatic settle();
    while (pend_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int tick_pct, input bit rate_zero);
    int unsigned rate, dh, glen, len;
    case ($urandom_range(0, 5))
      0: rate = 1;
      1: rate = 2;
      2: rate = 255;
      default: rate = $urandom_range(1, 6);
    endcase
    if (rate_zero) rate = 0;
    case ($urandom_range(0, 5))
      0: dh = 1;
      1: dh = 255;
      2: dh = 0;
      3: dh = $urandom_range(1, 12);
      default: dh = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 6))
      0: glen = 1;
      1: glen = 64;
      2: glen = 0;
      3: glen = $urandom_range(65, 127);
      4: glen = $urandom_range(2, 8);
      default: glen = $urandom_range(1, 64);
    endcase
    write_reg(REG_ENABLE, rate_zero || $urandom_range(0, 7) != 0, 1);
    write_reg(REG_TICKS, rate, 8);
    write_reg(REG_BAR_HEIGHT, dh, 8);
    write_reg(REG_GRAPH_LENGTH, glen, GLEN_W);
    write_reg(REG_COLOR_BOTTOM, ($urandom_range(0, 3) == 0) ? 0 : $urandom, COLOR_W);
    write_reg(REG_COLOR_TOP, ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom, COLOR_W);
    write_reg(REG_ORIGIN_X, ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095),
              ORG_W);
    write_reg(REG_ORIGIN_Y, ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095),
              ORG_W);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 7)), $urandom, CFG_DATA_W);
    len = used_len();
    repeat (n) begin
      if ($urandom_range(0, 99) < tick_pct)
        queue_tick(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                              : $urandom_range(0, 100));
      else
        queue_pixel(($urandom_range(0, 9) < 8) ? $urandom_range(0, len - 1)
                                              : $urandom_range(0, 63),
                    (dh_r > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, dh_r - 1)
                                                           : $urandom_range(0, 255));
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset
    queue_tick(100);
    queue_pixel(0, 0);
    settle();

    write_reg(REG_ENABLE, 1, 1);
    write_reg(REG_TICKS, 1, 8);
    write_reg(REG_BAR_HEIGHT, 255, 8);
    write_reg(REG_GRAPH_LENGTH, 64, GLEN_W);
    write_reg(REG_COLOR_BOTTOM, 24'hFFFFFF, COLOR_W);
    write_reg(REG_COLOR_TOP, 24'h000000, COLOR_W);
    write_reg(REG_ORIGIN_X, 4095, ORG_W);
    write_reg(REG_ORIGIN_Y, 4095, ORG_W);
    write_reg(REG_UNUSED_FIRST, 24'hFFFFFF, CFG_DATA_W);
    write_reg(REG_UNUSED_LAST, 24'h000001, CFG_DATA_W);
    queue_tick(0);
    queue_tick(127);
    queue_tick(100);
    queue_tick(50);
    queue_pixel(61, 0);
    queue_pixel(62, 254);
    queue_pixel(63, 128);
    queue_pixel(63, 127);
    queue_pixel(60, 254);
    queue_pixel(63, 255);
    settle();

    // zero height draws nothing
    write_reg(REG_BAR_HEIGHT, 0, 8);
    queue_pixel(61, 0);
    settle();

    // zero length acts as one; stored heights exceed the new height
    write_reg(REG_GRAPH_LENGTH, 0, GLEN_W);
    write_reg(REG_BAR_HEIGHT, 7, 8);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_tick(100);
    queue_pixel(0, 3);
    settle();

    // oversize length saturates
    write_reg(REG_GRAPH_LENGTH, 127, GLEN_W);
    queue_pixel(63, 6);
    queue_pixel(0, 6);
    queue_tick(30);
    queue_tick(60);
    queue_tick(90);
    settle();

    // shrink below the ring pointer
    write_reg(REG_GRAPH_LENGTH, 2, GLEN_W);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(2, 0);
    settle();

    // grow again before any tick; the ring pointer keeps its old value
    write_reg(REG_GRAPH_LENGTH, 64, GLEN_W);
    queue_pixel(0, 0);
    queue_pixel(62, 0);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 50;
      end else if (ph < 5) begin
        send_idle_pct = 50;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 1) run_phase(300, 92, 1'b1);
      else run_phase(70, 40, 1'b0);
    end

    if (errors == 0) begin
      $display("tb_scrolling_bar_graph_overlay: PASS");
    end else begin
      $display("tb_scrolling_bar_graph_overlay: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
